FILE: hw/rtl/double_ended_queue_unit_defines.svh
// Assertion macros for the double-ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DEQU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dequ assertion failed");
`define DEQU_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("dequ assertion failed");
`else
`define DEQU_ASSERT(lbl, clk, rst_n, prop)
`define DEQU_ASSERT_NEXT(lbl, clk, rst_n, cond, prop)
`endif

`endif

FILE: hw/rtl/dequ_pkg.sv
package dequ_pkg;

    localparam int DEQU_DEPTH = 16;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [2:0] CMD_PEEK_REAR  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        [2:0]  command;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic        [1:0]  status;
        logic        [4:0]  item_count;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        logic       use_rd;
        logic [1:0] status;
        logic [4:0] item_count;
        logic       is_empty;
    } t_s1;

endpackage

FILE: hw/rtl/double_ended_queue_unit.sv
// Bounded double-ended queue of DEPTH signed 32-bit values in a ring held in one
// single-port synchronous memory. Commands: push front/rear, pop front/rear, peek
// front/rear; each transaction returns one result with the value read, a status
// (ok, empty, full), the entry count after the command and an empty flag. Head
// pointer and count live in registers and are updated as a command is accepted,
// so one command is taken every cycle unless the output stall backs up stage 1.
// Results are read in stage 1 and registered out. Full/empty errors change nothing.
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEQU_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IdxW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam int SumW = CntW + 1;
    localparam logic [IdxW-1:0] IDX_LAST = IdxW'(DEPTH - 1);
    localparam logic [CntW-1:0] CNT_FULL = CntW'(DEPTH);
    localparam logic [SumW-1:0] SUM_DEPTH = SumW'(DEPTH);

    logic [31:0]     r_mem [DEPTH];
    logic [31:0]     r_rd_data;
    logic [IdxW-1:0] r_head, n_head;
    logic [CntW-1:0] r_count, n_count;
    logic            r_s1_valid;
    t_s1             r_s1, n_s1;
    logic            r_out_valid;
    t_out_item       r_out;

    logic            in_acc, s1_move;
    logic            mem_we, mem_re;
    logic [IdxW-1:0] mem_addr;
    logic [IdxW-1:0] head_dec, head_inc, tail_slot, rear_slot;
    logic [SumW-1:0] sum, last;
    logic [CntW+4:0] cnt_ext;

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign head_dec = (r_head == '0) ? IDX_LAST : r_head - 1'b1;
    assign head_inc = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
    assign sum      = SumW'(r_head) + SumW'(r_count);
    assign last     = sum - 1'b1;
    assign tail_slot = (sum >= SUM_DEPTH) ? IdxW'(sum - SUM_DEPTH) : IdxW'(sum);
    assign rear_slot = (last >= SUM_DEPTH) ? IdxW'(last - SUM_DEPTH) : IdxW'(last);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_head;
        n_s1.use_rd = 1'b0;
        n_s1.status = ST_OK;
        case (i_in_data.command)
            CMD_PUSH_FRONT: begin
                if (r_count == CNT_FULL) begin
                    n_s1.status = ST_FULL;
                end else begin
                    n_head   = head_dec;
                    n_count  = r_count + 1'b1;
                    mem_addr = head_dec;
                    mem_we   = in_acc;
                end
            end
            CMD_PUSH_REAR: begin
                if (r_count == CNT_FULL) begin
                    n_s1.status = ST_FULL;
                end else begin
                    n_count  = r_count + 1'b1;
                    mem_addr = tail_slot;
                    mem_we   = in_acc;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (r_count == '0) begin
                    n_s1.status = ST_EMPTY;
                end else begin
                    n_s1.use_rd = 1'b1;
                    mem_addr    = r_head;
                    mem_re      = in_acc;
                    if (i_in_data.command == CMD_POP_FRONT) begin
                        n_head  = head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_POP_REAR, CMD_PEEK_REAR: begin
                if (r_count == '0) begin
                    n_s1.status = ST_EMPTY;
                end else begin
                    n_s1.use_rd = 1'b1;
                    mem_addr    = rear_slot;
                    mem_re      = in_acc;
                    if (i_in_data.command == CMD_POP_REAR) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        cnt_ext         = {5'b0, n_count};
        n_s1.item_count = cnt_ext[4:0];
        n_s1.is_empty   = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_in_data.push_value;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_head     <= n_head;
                r_count    <= n_count;
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out.read_value <= r_s1.use_rd ? r_rd_data : '0;
            r_out.status     <= r_s1.status;
            r_out.item_count <= r_s1.item_count;
            r_out.is_empty   <= r_s1.is_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `DEQU_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL)
    `DEQU_ASSERT(a_head_bound, i_clk, i_rst_n, r_head <= IDX_LAST)
    `DEQU_ASSERT(a_empty_status, i_clk, i_rst_n, !(r_s1_valid && r_s1.status == ST_EMPTY) || r_s1.is_empty)
    `DEQU_ASSERT(a_full_no_write, i_clk, i_rst_n, !(mem_we && r_count == CNT_FULL))
    `DEQU_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, mem_we, r_count == $past(r_count) + 1'b1)

endmodule

FILE: verif/double_ended_queue_unit_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
    import dequ_pkg::*;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT = 34;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // expectation that rides along with the current input transaction
    logic      drv_typed = 1'b0;
    t_out_item drv_typed_val = '0;

    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    // deque shadow state
    logic signed [31:0] ring_mem [DEQU_DEPTH];
    int ring_head = 0;
    int ring_count = 0;
    int peak_count = 0;

    t_out_item pending_results[$];
    int fail_count = 0;
    int cmds_sent = 0;
    int results_checked = 0;
    int full_errs = 0;
    int empty_errs = 0;
    int idle_cycles = 0;

    t_in_item  dir_cmd[$];
    bit        dir_typed[$];
    t_out_item dir_exp[$];

    double_ended_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_out_item deque_apply(t_in_item it);
        t_out_item r;
        int slot;
        r = '0;
        case (it.command)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (ring_count >= DEQU_DEPTH) begin
                    r.status = ST_FULL;
                end else if (it.command == CMD_PUSH_FRONT) begin
                    ring_head = (ring_head + DEQU_DEPTH - 1) % DEQU_DEPTH;
                    ring_mem[ring_head] = it.push_value;
                    ring_count++;
                end else begin
                    slot = (ring_head + ring_count) % DEQU_DEPTH;
                    ring_mem[slot] = it.push_value;
                    ring_count++;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = ring_mem[ring_head];
                    if (it.command == CMD_POP_FRONT) begin
                        ring_head = (ring_head + 1) % DEQU_DEPTH;
                        ring_count--;
                    end
                end
            end
            CMD_POP_REAR, CMD_PEEK_REAR: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot = (ring_head + ring_count - 1) % DEQU_DEPTH;
                    r.read_value = ring_mem[slot];
                    if (it.command == CMD_POP_REAR) begin
                        ring_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        if (ring_count > peak_count) begin
            peak_count = ring_count;
        end
        r.item_count = ring_count[4:0];
        r.is_empty = (ring_count == 0);
        return r;
    endfunction

    function automatic t_in_item rand_cmd(int push_pct);
        t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            it.command = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        end else if (r < 96) begin
            case ($urandom_range(0, 3))
                0: it.command = CMD_POP_FRONT;
                1: it.command = CMD_POP_REAR;
                2: it.command = CMD_PEEK_FRONT;
                default: it.command = CMD_PEEK_REAR;
            endcase
        end else begin
            it.command = $urandom_range(0, 1) ? CMD_RSVD7 : CMD_RSVD6;
        end
        case ($urandom_range(0, 9))
            0: it.push_value = 32'h8000_0000;
            1: it.push_value = 32'h7fff_ffff;
            2: it.push_value = '1;
            3: it.push_value = '0;
            default: it.push_value = $urandom;
        endcase
        return it;
    endfunction

    task automatic add_row(logic [2:0] cmd, logic [31:0] val, bit typed,
                           logic [31:0] rd, logic [1:0] st, logic [4:0] cnt, logic emp);
        t_in_item it;
        t_out_item ex;
        it.command = cmd;
        it.push_value = val;
        ex.read_value = rd;
        ex.status = st;
        ex.item_count = cnt;
        ex.is_empty = emp;
        dir_cmd.push_back(it);
        dir_typed.push_back(typed);
        dir_exp.push_back(ex);
    endtask

    // called just after a rising edge; returns at the edge that accepts the item
    task automatic send_cmd(t_in_item it, bit typed, t_out_item ex);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        drv_typed <= typed;
        drv_typed_val <= ex;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        cmds_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // receiver: random stalls, a quiet stretch, and one long hold-off
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // scoreboard: record accepted commands, then check the result channel
    always @(posedge i_clk) begin
        t_out_item pred;
        t_out_item ex;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pred = deque_apply(i_in_data);
                pending_results.push_back(drv_typed ? drv_typed_val : pred);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result rd=%0d st=%0d cnt=%0d empty=%0b", $time,
                             o_out_data.read_value, o_out_data.status,
                             o_out_data.item_count, o_out_data.is_empty);
                    fail_count++;
                end else begin
                    ex = pending_results[0];
                    pending_results.delete(0);
                    results_checked++;
                    if (ex.status == ST_FULL) full_errs++;
                    if (ex.status == ST_EMPTY) empty_errs++;
                    if (o_out_data.read_value !== ex.read_value ||
                        o_out_data.status !== ex.status ||
                        o_out_data.item_count !== ex.item_count ||
                        o_out_data.is_empty !== ex.is_empty) begin
                        $display("%0t: mismatch exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 $time, ex.read_value, ex.status, ex.item_count, ex.is_empty,
                                 o_out_data.read_value, o_out_data.status,
                                 o_out_data.item_count, o_out_data.is_empty);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        t_out_item none;
        int pct;
        none = '0;

        add_row(CMD_POP_FRONT,  '0, 1'b1, '0, ST_EMPTY, 5'd0, 1'b1);
        add_row(CMD_POP_REAR,   '0, 1'b1, '0, ST_EMPTY, 5'd0, 1'b1);
        add_row(CMD_PEEK_FRONT, '0, 1'b1, '0, ST_EMPTY, 5'd0, 1'b1);
        add_row(CMD_PEEK_REAR,  '0, 1'b1, '0, ST_EMPTY, 5'd0, 1'b1);
        add_row(CMD_RSVD6,      '1, 1'b1, '0, ST_OK,    5'd0, 1'b1);
        add_row(CMD_RSVD7,      '1, 1'b1, '0, ST_OK,    5'd0, 1'b1);
        add_row(CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b1, '0, ST_OK, 5'd1, 1'b0);
        add_row(CMD_PUSH_REAR,  32'h8000_0000, 1'b1, '0, ST_OK, 5'd2, 1'b0);
        add_row(CMD_PEEK_FRONT, '0, 1'b1, 32'h7fff_ffff, ST_OK, 5'd2, 1'b0);
        add_row(CMD_PEEK_REAR,  '0, 1'b1, 32'h8000_0000, ST_OK, 5'd2, 1'b0);
        add_row(CMD_PUSH_FRONT, '1, 1'b0, '0, ST_OK, 5'd0, 1'b0);
        add_row(CMD_PUSH_REAR,  '0, 1'b0, '0, ST_OK, 5'd0, 1'b0);
        add_row(CMD_PUSH_FRONT, 32'h5555_5555, 1'b0, '0, ST_OK, 5'd0, 1'b0);
        add_row(CMD_PUSH_REAR,  32'haaaa_aaaa, 1'b0, '0, ST_OK, 5'd0, 1'b0);
        for (int k = 0; k < 10; k++) begin
            add_row(k[0] ? CMD_PUSH_REAR : CMD_PUSH_FRONT, 32'h0101_0000 + k, 1'b0,
                    '0, ST_OK, 5'd0, 1'b0);
        end
        add_row(CMD_PUSH_REAR,  32'h1234_5678, 1'b1, '0, ST_FULL, 5'd16, 1'b0);
        add_row(CMD_POP_FRONT,  '0, 1'b0, '0, ST_OK, 5'd0, 1'b0);
        add_row(CMD_POP_REAR,   '0, 1'b0, '0, ST_OK, 5'd0, 1'b0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_cmd[k]) begin
            send_cmd(dir_cmd[k], dir_typed[k], dir_exp[k]);
        end

        quiet = 1'b1;
        repeat (100) send_cmd(rand_cmd(50), 1'b0, none);
        quiet = 1'b0;

        // long receiver hold-off while commands keep coming
        hold_req = 1'b1;
        repeat (40) send_cmd(rand_cmd(80), 1'b0, none);
        wait (hold_done);
        @(posedge i_clk);
        drain_results();
        @(posedge i_clk);

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 3)
                0: pct = 75;
                1: pct = 25;
                default: pct = 50;
            endcase
            repeat (40) send_cmd(rand_cmd(pct), 1'b0, none);
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d commands, %0d results checked: %0d full and %0d empty errors,",
                 cmds_sent, results_checked, full_errs, empty_errs);
        $display("peak occupancy %0d of %0d, with one long output hold-off.",
                 peak_count, DEQU_DEPTH);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
